FILE: hw/rtl/fpr_pkg.sv
package fpr_pkg;
  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int FILL_W = ADDR_W + 1;
  localparam int NEED_W = (FILL_W > 7) ? FILL_W + 1 : 8;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] CRC_HOLD = 2'd0;
  localparam logic [1:0] CRC_CLR  = 2'd1;
  localparam logic [1:0] CRC_LOAD = 2'd2;
  localparam logic [1:0] CRC_STEP = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } crc_ctrl_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_ctrl_t;

  // Fold a ring position (below twice the depth) back into range.
  function automatic logic [ADDR_W-1:0] wrap(input logic [FILL_W-1:0] pos);
    logic [FILL_W-1:0] folded;
    folded = (pos >= FILL_W'(BUFFER_DEPTH)) ? pos - FILL_W'(BUFFER_DEPTH) : pos;
    return folded[ADDR_W-1:0];
  endfunction
endpackage

FILE: hw/rtl/fpr_mem.sv
module fpr_mem
  import fpr_pkg::*;
(
  input  logic       clk,
  input  mem_ctrl_t  ctrl,
  output logic [7:0] rd_data
);
  logic [7:0] store [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      store[ctrl.wr_addr] <= ctrl.wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= store[ctrl.rd_addr];
    end
  end
endmodule

FILE: hw/rtl/fpr_crc.sv
module fpr_crc
  import fpr_pkg::*;
(
  input  logic        clk,
  input  crc_ctrl_t   ctrl,
  output logic [15:0] crc
);
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CRC_CLR:  crc <= 16'h0000;
      CRC_LOAD: crc <= crc ^ {ctrl.data, 8'h00};
      CRC_STEP: crc <= crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
      default:  crc <= crc;
    endcase
  end
endmodule

FILE: hw/rtl/framed_packet_receiver.sv
// Length-prefixed frame receiver with a CRC-16/XMODEM check.
// Slave channel: one transaction per received byte; tdata holds rx_byte,
// tuser holds flush (empty the ring, ignore the byte).
// Master channel: for every input transaction, zero or more payload-byte
// results followed by one status result (tuser[1] run_end set). tlast marks
// the last payload byte of a frame. tdata carries the wrapping counters.
// The user must write max_payload_len (reset 59) via cfg_we/cfg_data only
// while the block is idle; the block does not enforce this. s_tready is high
// only in the idle state. A flush or a byte that hits a full ring goes to its
// status result without a scan. Any other byte rescans the ring from its
// oldest byte through one shared memory read port and a bit-serial CRC unit:
// a bad start byte is dropped, a header may be dropped on its length or end
// byte, else the CRC runs bit by bit over the payload, the checksum bytes are
// compared, then one payload result leaves per cycle while the output is free.
// Results leave through one output register; when the receiver stalls the
// sequencer holds in place until the register is taken.
// Reset clears the ring indices, all counters and the output valid; the
// byte store itself needs no clearing, since only filled entries are read.
module framed_packet_receiver
  import fpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  input  logic         s_tuser,   // [0] flush
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] payload_byte, [13:8] payload_length, [45:14] bytes_in_count,
  // [77:46] frames_ok_count, [109:78] framing_error_count,
  // [141:110] crc_error_count, [173:142] oversized_count, [175:174] zero
  output logic [175:0] m_tdata,
  output logic [1:0]   m_tuser,   // [0] kind, [1] run_end
  output logic         m_tlast,   // frame_end
  input  logic         cfg_we,
  input  logic [5:0]   cfg_data
);
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_GOT_S  = 4'd2;
  localparam logic [3:0] ST_LEN    = 4'd3;
  localparam logic [3:0] ST_LCHK   = 4'd4;
  localparam logic [3:0] ST_END    = 4'd5;
  localparam logic [3:0] ST_CRC_B  = 4'd6;
  localparam logic [3:0] ST_CRC_BIT = 4'd7;
  localparam logic [3:0] ST_CK1    = 4'd8;
  localparam logic [3:0] ST_CK2    = 4'd9;
  localparam logic [3:0] ST_EMIT   = 4'd10;
  localparam logic [3:0] ST_FINISH = 4'd11;

  logic [3:0]        state, state_next;
  logic [ADDR_W-1:0] rp, rp_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [31:0]       bytes_seen, good_frames, fe_seen, ce_seen, ov_seen;
  logic              inc_bytes, inc_good, inc_fe, inc_ce, inc_ov;
  logic [5:0]        max_len;
  logic [2:0]        start, start_next;
  logic [23:0]       len, len_next;
  logic [5:0]        k, k_next;
  logic [2:0]        bit_cnt, bit_cnt_next;
  logic [7:0]        crc_hi, crc_hi_next;

  mem_ctrl_t         mem_c;
  logic [7:0]        rd_data;
  logic [FILL_W-1:0] rd_off;
  crc_ctrl_t         crc_c;
  logic [15:0]       crc;

  logic              slot_free;
  logic              emit_pay, emit_stat;
  logic [5:0]        len6;
  logic [FILL_W-1:0] len_f;
  logic [NEED_W-1:0] need;

  fpr_mem u_mem (.clk(clk), .ctrl(mem_c), .rd_data(rd_data));
  fpr_crc u_crc (.clk(clk), .ctrl(crc_c), .crc(crc));

  assign s_tready  = (state == ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;
  assign len6      = len[5:0];
  assign len_f     = FILL_W'(len6);
  assign need      = NEED_W'(len6) + NEED_W'(5);

  always_comb begin
    state_next   = state;
    rp_next      = rp;
    fill_next    = fill;
    start_next   = start;
    len_next     = len;
    k_next       = k;
    bit_cnt_next = bit_cnt;
    crc_hi_next  = crc_hi;
    inc_bytes    = 1'b0;
    inc_good     = 1'b0;
    inc_fe       = 1'b0;
    inc_ce       = 1'b0;
    inc_ov       = 1'b0;
    emit_pay     = 1'b0;
    emit_stat    = 1'b0;
    rd_off       = '0;
    mem_c.wr_en   = 1'b0;
    mem_c.wr_addr = wrap(FILL_W'(rp) + fill);
    mem_c.wr_data = s_tdata;
    mem_c.rd_en   = 1'b0;
    crc_c.op      = CRC_HOLD;
    crc_c.data    = rd_data;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser) begin
            // flush: empty the ring, no counter moves
            rp_next    = '0;
            fill_next  = '0;
            state_next = ST_FINISH;
          end else if (fill == FILL_W'(BUFFER_DEPTH)) begin
            // ring full: restart it with just this byte, no scan
            inc_bytes     = 1'b1;
            mem_c.wr_en   = 1'b1;
            mem_c.wr_addr = '0;
            rp_next       = '0;
            fill_next     = FILL_W'(1);
            state_next    = ST_FINISH;
          end else begin
            inc_bytes   = 1'b1;
            mem_c.wr_en = 1'b1;
            fill_next   = fill + FILL_W'(1);
            state_next  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (fill == '0) begin
          state_next = ST_FINISH;
        end else begin
          mem_c.rd_en = 1'b1;
          rd_off      = '0;
          state_next  = ST_GOT_S;
        end
      end
      ST_GOT_S: begin
        if (rd_data != 8'd2 && rd_data != 8'd3 && rd_data != 8'd4) begin
          inc_fe     = 1'b1;
          rp_next    = wrap(FILL_W'(rp) + FILL_W'(1));
          fill_next  = fill - FILL_W'(1);
          state_next = ST_SCAN;
        end else if (fill < FILL_W'(rd_data[2:0])) begin
          state_next = ST_FINISH;
        end else begin
          start_next  = rd_data[2:0];
          len_next    = '0;
          k_next      = 6'd1;
          mem_c.rd_en = 1'b1;
          rd_off      = FILL_W'(1);
          state_next  = ST_LEN;
        end
      end
      ST_LEN: begin
        // shift in one big-endian length byte
        len_next = {len[15:0], rd_data};
        if (k == 6'(start - 3'd1)) begin
          state_next = ST_LCHK;
        end else begin
          k_next      = k + 6'd1;
          mem_c.rd_en = 1'b1;
          rd_off      = FILL_W'(k + 6'd1);
        end
      end
      ST_LCHK: begin
        if ((start == 3'd2 && len == 24'd0) ||
            (start == 3'd3 && len < 24'd255) ||
            (start == 3'd4 && len < 24'd65535)) begin
          inc_fe     = 1'b1;
          rp_next    = wrap(FILL_W'(rp) + FILL_W'(1));
          fill_next  = fill - FILL_W'(1);
          state_next = ST_SCAN;
        end else if (len > 24'(max_len)) begin
          inc_ov     = 1'b1;
          rp_next    = wrap(FILL_W'(rp) + FILL_W'(1));
          fill_next  = fill - FILL_W'(1);
          state_next = ST_SCAN;
        end else if (NEED_W'(fill) < need) begin
          state_next = ST_FINISH;
        end else begin
          // only a two-byte header gets here; fetch the end byte
          mem_c.rd_en = 1'b1;
          rd_off      = len_f + FILL_W'(4);
          state_next  = ST_END;
        end
      end
      ST_END: begin
        if (rd_data != 8'd3) begin
          inc_fe     = 1'b1;
          rp_next    = wrap(FILL_W'(rp) + FILL_W'(1));
          fill_next  = fill - FILL_W'(1);
          state_next = ST_SCAN;
        end else begin
          crc_c.op    = CRC_CLR;
          k_next      = '0;
          mem_c.rd_en = 1'b1;
          rd_off      = FILL_W'(2);
          state_next  = ST_CRC_B;
        end
      end
      ST_CRC_B: begin
        crc_c.op     = CRC_LOAD;
        bit_cnt_next = '0;
        state_next   = ST_CRC_BIT;
      end
      ST_CRC_BIT: begin
        crc_c.op     = CRC_STEP;
        bit_cnt_next = bit_cnt + 3'd1;
        if (bit_cnt == 3'd7) begin
          k_next      = k + 6'd1;
          mem_c.rd_en = 1'b1;
          if (k + 6'd1 == len6) begin
            rd_off     = len_f + FILL_W'(2);
            state_next = ST_CK1;
          end else begin
            rd_off     = FILL_W'(k) + FILL_W'(3);
            state_next = ST_CRC_B;
          end
        end
      end
      ST_CK1: begin
        crc_hi_next = rd_data;
        mem_c.rd_en = 1'b1;
        rd_off      = len_f + FILL_W'(3);
        state_next  = ST_CK2;
      end
      ST_CK2: begin
        if (crc != {crc_hi, rd_data}) begin
          inc_ce     = 1'b1;
          rp_next    = wrap(FILL_W'(rp) + FILL_W'(1));
          fill_next  = fill - FILL_W'(1);
          state_next = ST_SCAN;
        end else begin
          inc_good    = 1'b1;
          k_next      = '0;
          mem_c.rd_en = 1'b1;
          rd_off      = FILL_W'(2);
          state_next  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hand out one payload byte per free output slot
        if (slot_free) begin
          emit_pay = 1'b1;
          if (k + 6'd1 == len6) begin
            rp_next    = wrap(FILL_W'(rp) + len_f + FILL_W'(5));
            fill_next  = fill - len_f - FILL_W'(5);
            state_next = ST_SCAN;
          end else begin
            k_next      = k + 6'd1;
            mem_c.rd_en = 1'b1;
            rd_off      = FILL_W'(k) + FILL_W'(3);
          end
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          emit_stat  = 1'b1;
          if (fill == '0) begin
            rp_next = '0;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    mem_c.rd_addr = wrap(FILL_W'(rp) + rd_off);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rp          <= '0;
      fill        <= '0;
      bytes_seen  <= '0;
      good_frames <= '0;
      fe_seen     <= '0;
      ce_seen     <= '0;
      ov_seen     <= '0;
      max_len     <= 6'd59;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      rp    <= rp_next;
      fill  <= fill_next;
      if (inc_bytes) bytes_seen  <= bytes_seen + 32'd1;
      if (inc_good)  good_frames <= good_frames + 32'd1;
      if (inc_fe)    fe_seen     <= fe_seen + 32'd1;
      if (inc_ce)    ce_seen     <= ce_seen + 32'd1;
      if (inc_ov)    ov_seen     <= ov_seen + 32'd1;
      if (cfg_we)    max_len     <= cfg_data;
      if (emit_pay || emit_stat) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload side: no reset needed
  always_ff @(posedge clk) begin
    start   <= start_next;
    len     <= len_next;
    k       <= k_next;
    bit_cnt <= bit_cnt_next;
    crc_hi  <= crc_hi_next;
    if (emit_pay || emit_stat) begin
      m_tdata <= {2'b00, ov_seen, ce_seen, fe_seen, good_frames, bytes_seen,
                  emit_pay ? len6 : 6'd0, emit_pay ? rd_data : 8'd0};
      m_tuser <= {emit_stat, emit_pay};
      m_tlast <= emit_pay && (k + 6'd1 == len6);
    end
  end
endmodule

FILE: dv/testbench.sv
module testbench;
  import fpr_pkg::*;

  // one expected output transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  pbyte;
    logic        fend;
    logic        rend;
    logic [5:0]  plen;
    logic [31:0] n_bytes;
    logic [31:0] n_ok;
    logic [31:0] n_framing;
    logic [31:0] n_crc;
    logic [31:0] n_oversized;
  } rx_result_t;

  // directed row: byte, flush, and optional typed-in status counters
  typedef struct {
    logic [7:0]  rx;
    logic        fl;
    logic        known;
    logic [31:0] k_bytes;
    logic [31:0] k_ok;
    logic [31:0] k_framing;
    logic [31:0] k_crc;
    logic [31:0] k_oversized;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [175:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic [5:0]   cfg_data = 6'd59;

  framed_packet_receiver u_top (.*);

  always #10 clk = ~clk;

  // shadow of the receiver state
  logic [7:0]  ring [BUFFER_DEPTH];
  int unsigned rd_pos, fill;
  logic [31:0] c_bytes, c_ok, c_framing, c_crc, c_oversized;
  logic [5:0]  max_len;
  rx_result_t  pending_results [$];
  int          err_cnt = 0;
  longint      cycle_cnt = 0;
  bit          quiet_sink = 0;
  bit          quiet_src = 0;

  function automatic logic [7:0] ring_at(int unsigned off);
    return ring[(rd_pos + off) % BUFFER_DEPTH];
  endfunction

  function automatic logic [15:0] xmodem_over_ring(int unsigned first, int unsigned count);
    logic [15:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < count; i++) begin
      acc ^= {ring_at(first + i), 8'h00};
      for (int b = 0; b < 8; b++)
        acc = acc[15] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
    end
    return acc;
  endfunction

  function automatic rx_result_t mk_result(logic kind, logic [7:0] pb, logic fe, logic re,
                                           logic [5:0] pl);
    rx_result_t r;
    r = '{kind, pb, fe, re, pl, c_bytes, c_ok, c_framing, c_crc, c_oversized};
    return r;
  endfunction

  // 0 wait for bytes, 1 drop oldest byte, 2 good frame
  function automatic int scan_ring(output int unsigned flen);
    int unsigned s, len;
    flen = 0;
    if (fill == 0) return 0;
    s = ring_at(0);
    if (s != 2 && s != 3 && s != 4) begin
      c_framing++;
      return 1;
    end
    if (fill < s) return 0;
    if (s == 2) len = ring_at(1);
    else if (s == 3) len = {ring_at(1), ring_at(2)};
    else len = {ring_at(1), ring_at(2), ring_at(3)};
    if ((s == 2 && len < 1) || (s == 3 && len < 255) || (s == 4 && len < 65535)) begin
      c_framing++;
      return 1;
    end
    if (len > max_len) begin
      c_oversized++;
      return 1;
    end
    if (fill < len + s + 3) return 0;
    if (ring_at(s + len + 2) != 8'd3) begin
      c_framing++;
      return 1;
    end
    if (xmodem_over_ring(s, len) != {ring_at(s + len), ring_at(s + len + 1)}) begin
      c_crc++;
      return 1;
    end
    c_ok++;
    flen = len;
    return 2;
  endfunction

  // advance the shadow by one accepted byte and queue what it produces
  function automatic void predict_receive(logic [7:0] rx, logic fl);
    int unsigned flen, s, n;
    int res;
    n = 0;
    if (fl) begin
      rd_pos = 0;
      fill = 0;
    end else begin
      c_bytes++;
      if (fill >= BUFFER_DEPTH) begin
        rd_pos = 0;
        ring[0] = rx;
        fill = 1;
      end else begin
        ring[(rd_pos + fill) % BUFFER_DEPTH] = rx;
        fill++;
        forever begin
          res = scan_ring(flen);
          if (res == 0) break;
          if (res == 1) begin
            rd_pos = (rd_pos + 1) % BUFFER_DEPTH;
            fill--;
            continue;
          end
          s = ring_at(0);
          for (int unsigned i = 0; i < flen; i++)
            if (n < 60) begin
              pending_results.push_back(mk_result(1'b1, ring_at(s + i), i + 1 == flen, 1'b0,
                                                  6'(flen)));
              n++;
            end
          rd_pos = (rd_pos + flen + s + 3) % BUFFER_DEPTH;
          fill -= flen + s + 3;
        end
        if (fill == 0) rd_pos = 0;
      end
    end
    pending_results.push_back(mk_result(1'b0, 8'h00, 1'b0, 1'b1, 6'd0));
  endfunction

  // sample the master side at the rising edge
  always @(posedge clk) begin
    rx_result_t exp_r, got;
    cycle_cnt++;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser[0], m_tdata[7:0], m_tlast, m_tuser[1], m_tdata[13:8], m_tdata[45:14],
              m_tdata[77:46], m_tdata[109:78], m_tdata[141:110], m_tdata[173:142]};
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction %h", got);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.kind != exp_r.kind) begin
          $error("kind exp %0d got %0d", exp_r.kind, got.kind); err_cnt++; end
        if (got.pbyte != exp_r.pbyte) begin
          $error("payload_byte exp %0d got %0d", exp_r.pbyte, got.pbyte); err_cnt++; end
        if (got.fend != exp_r.fend) begin
          $error("frame_end exp %0d got %0d", exp_r.fend, got.fend); err_cnt++; end
        if (got.rend != exp_r.rend) begin
          $error("run_end exp %0d got %0d", exp_r.rend, got.rend); err_cnt++; end
        if (got.plen != exp_r.plen) begin
          $error("payload_length exp %0d got %0d", exp_r.plen, got.plen); err_cnt++; end
        if (got.n_bytes != exp_r.n_bytes) begin
          $error("bytes_in_count exp %0d got %0d", exp_r.n_bytes, got.n_bytes); err_cnt++; end
        if (got.n_ok != exp_r.n_ok) begin
          $error("frames_ok_count exp %0d got %0d", exp_r.n_ok, got.n_ok); err_cnt++; end
        if (got.n_framing != exp_r.n_framing) begin
          $error("framing_error_count exp %0d got %0d", exp_r.n_framing, got.n_framing);
          err_cnt++;
        end
        if (got.n_crc != exp_r.n_crc) begin
          $error("crc_error_count exp %0d got %0d", exp_r.n_crc, got.n_crc); err_cnt++; end
        if (got.n_oversized != exp_r.n_oversized) begin
          $error("oversized_count exp %0d got %0d", exp_r.n_oversized, got.n_oversized);
          err_cnt++;
        end
      end
    end
  end

  // sink back-pressure, changed at the falling edge
  always @(negedge clk)
    m_tready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 14);

  // timeout
  always @(posedge clk)
    if (cycle_cnt > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end

  // offer one transaction and hold it until taken
  task automatic send_byte(logic [7:0] rx, logic fl);
    @(negedge clk);
    while (!quiet_src && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rx;
    s_tuser  <= fl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_receive(rx, fl);
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_max_len(logic [5:0] v);
    drain_and_settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    max_len = v;
  endtask

  // push a whole frame of len bytes through, optionally corrupting it
  task automatic send_frame(int unsigned len, int unsigned start, int unsigned flaw);
    logic [7:0]  pay [$];
    logic [15:0] acc;
    for (int unsigned i = 0; i < len; i++) pay.push_back(8'($urandom));
    acc = '0;
    foreach (pay[i]) begin
      acc ^= {pay[i], 8'h00};
      for (int b = 0; b < 8; b++) acc = acc[15] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
    end
    if (flaw == 1) acc ^= 16'(1 << $urandom_range(15));
    send_byte(8'(start), 1'b0);
    if (start == 3) send_byte(8'(len >> 8), 1'b0);
    if (start == 4) begin
      send_byte(8'(len >> 16), 1'b0);
      send_byte(8'(len >> 8), 1'b0);
    end
    send_byte(8'(len), 1'b0);
    foreach (pay[i]) send_byte(pay[i], 1'b0);
    send_byte(acc[15:8], 1'b0);
    send_byte(acc[7:0], 1'b0);
    send_byte(flaw == 2 ? 8'($urandom_range(4, 255)) : 8'd3, 1'b0);
  endtask

  stim_row_t dir_rows [] = '{
    // flush right after reset: all counters still zero
    '{8'hFF, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    // bad start byte: one framing error
    '{8'h00, 1'b0, 1'b1, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0},
    '{8'hFF, 1'b0, 1'b1, 32'd2, 32'd0, 32'd2, 32'd0, 32'd0},
    // zero length after a two-byte header
    '{8'h02, 1'b0, 1'b1, 32'd3, 32'd0, 32'd2, 32'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 32'd4, 32'd0, 32'd4, 32'd0, 32'd0},
    // non-minimal length in a three-byte header
    '{8'h03, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h05, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    // non-minimal length in a four-byte header
    '{8'h04, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h01, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    // oversized: length 60 above the reset limit
    '{8'h02, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h3C, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    // flush mid-frame
    '{8'h02, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h00, 1'b1, 1'b0, 0, 0, 0, 0, 0},
    // one-byte frame, payload 0x00, crc 0x0000, good end
    '{8'h02, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h01, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{8'h03, 1'b0, 1'b0, 0, 0, 0, 0, 0}
  };

  initial begin
    rx_result_t last_status;
    int unsigned pick;
    rd_pos = 0; fill = 0; max_len = 6'd59;
    c_bytes = 0; c_ok = 0; c_framing = 0; c_crc = 0; c_oversized = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].rx, dir_rows[i].fl);
      if (dir_rows[i].known) begin
        last_status = pending_results[pending_results.size() - 1];
        if (last_status.n_bytes != dir_rows[i].k_bytes ||
            last_status.n_ok != dir_rows[i].k_ok ||
            last_status.n_framing != dir_rows[i].k_framing ||
            last_status.n_crc != dir_rows[i].k_crc ||
            last_status.n_oversized != dir_rows[i].k_oversized) begin
          $error("directed row %0d: predictor disagrees with table", i);
          err_cnt++;
        end
      end
    end
    // a CRC flaw and an end-byte flaw
    send_frame(1, 2, 1);
    send_frame(1, 2, 2);
    // fill the ring past full with a frame too long to finish
    write_max_len(6'd63);
    send_byte(8'h02, 1'b0);
    send_byte(8'd63, 1'b0);
    for (int i = 0; i < 63; i++) send_byte(8'($urandom), 1'b0);
    send_byte(8'h00, 1'b1);

    // random part, through several limits
    for (int phase = 0; phase < 3; phase++) begin
      write_max_len(phase == 0 ? 6'd59 : phase == 1 ? 6'd1 : 6'($urandom_range(1, 63)));
      quiet_src  = (phase == 2);
      quiet_sink = (phase == 2);
      for (int k = 0; k < (phase == 2 ? 3 : 2); k++) begin
        pick = $urandom_range(99);
        if (pick < 60) send_frame($urandom_range(1, 4), 2, 0);
        else if (pick < 70) send_frame($urandom_range(1, 4), 2, $urandom_range(1, 2));
        else if (pick < 80) send_byte(8'($urandom), 1'b0);
        else if (pick < 85) send_byte(8'($urandom), 1'b1);
        else if (pick < 90) begin
          send_byte(8'h03, 1'b0);
          send_byte(8'($urandom), 1'b0);
          send_byte(8'($urandom), 1'b0);
        end else begin
          send_byte(8'h04, 1'b0);
          send_byte(8'($urandom_range(0, 1)), 1'b0);
          send_byte(8'($urandom), 1'b0);
          send_byte(8'($urandom), 1'b0);
        end
      end
    end
    quiet_src = 0;
    quiet_sink = 0;
    drain_and_settle();
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_mem.sv
hw/rtl/fpr_crc.sv
hw/rtl/framed_packet_receiver.sv
dv/testbench.sv
